FILE: design/i2r_pkg.sv
// ----------------------------------------------------------------------------
// i2r_pkg
// Shared types, constants and numeral tables for the integer to Roman
// numeral converter.
// ----------------------------------------------------------------------------
package i2r_pkg;

   localparam int unsigned ValueWidth  = 12;
   localparam int unsigned LetterWidth = 7;
   localparam int unsigned IdxWidth    = 4;
   localparam int unsigned StepWidth   = 2;

   localparam logic [ValueWidth-1:0] MAX_VALUE = 12'd3999;

   localparam logic [LetterWidth-1:0] CHAR_M    = 7'h4D;
   localparam logic [LetterWidth-1:0] CHAR_D    = 7'h44;
   localparam logic [LetterWidth-1:0] CHAR_C    = 7'h43;
   localparam logic [LetterWidth-1:0] CHAR_L    = 7'h4C;
   localparam logic [LetterWidth-1:0] CHAR_X    = 7'h58;
   localparam logic [LetterWidth-1:0] CHAR_V    = 7'h56;
   localparam logic [LetterWidth-1:0] CHAR_I    = 7'h49;
   localparam logic [LetterWidth-1:0] CHAR_NONE = 7'h00;

   typedef logic [StepWidth-1:0] step_type;

   // microprogram step addresses
   localparam step_type STEP_IDLE   = 2'd0;
   localparam step_type STEP_FIRST  = 2'd1;
   localparam step_type STEP_SECOND = 2'd2;
   localparam step_type STEP_ERROR  = 2'd3;

   typedef enum logic [1:0] {
      EMIT_NONE   = 2'd0,
      EMIT_FIRST  = 2'd1,
      EMIT_SECOND = 2'd2,
      EMIT_ERROR  = 2'd3
   } emit_type;

   typedef enum logic [2:0] {
      COND_NEVER  = 3'd0,
      COND_NO_REQ = 3'd1,
      COND_BAD    = 3'd2,
      COND_PAIR   = 3'd3,
      COND_DONE   = 3'd4
   } cond_type;

   // one control word of the microprogram
   typedef struct packed {
      logic     accept;
      emit_type emit_sel;
      cond_type cond_a;
      step_type tgt_a;
      cond_type cond_b;
      step_type tgt_b;
      step_type tgt_def;
   } ctl_word_type;

   // datapath status seen by the sequencer
   typedef struct packed {
      logic no_req;
      logic bad_value;
      logic pair;
      logic done;
      logic stall;
   } cond_flags_type;

   // largest numeral symbol (single or subtractive pair) not above v
   function automatic logic [IdxWidth-1:0] greedy_idx(input logic [ValueWidth-1:0] v);
      logic [IdxWidth-1:0] idx;
      priority if (v >= 12'd1000) idx = 4'd0;
      else if (v >= 12'd900)      idx = 4'd1;
      else if (v >= 12'd500)      idx = 4'd2;
      else if (v >= 12'd400)      idx = 4'd3;
      else if (v >= 12'd100)      idx = 4'd4;
      else if (v >= 12'd90)       idx = 4'd5;
      else if (v >= 12'd50)       idx = 4'd6;
      else if (v >= 12'd40)       idx = 4'd7;
      else if (v >= 12'd10)       idx = 4'd8;
      else if (v >= 12'd9)        idx = 4'd9;
      else if (v >= 12'd5)        idx = 4'd10;
      else if (v >= 12'd4)        idx = 4'd11;
      else                        idx = 4'd12;
      return idx;
   endfunction

   function automatic logic [ValueWidth-1:0] sym_weight(input logic [IdxWidth-1:0] idx);
      logic [ValueWidth-1:0] w;
      unique case (idx)
         4'd0:    w = 12'd1000;
         4'd1:    w = 12'd900;
         4'd2:    w = 12'd500;
         4'd3:    w = 12'd400;
         4'd4:    w = 12'd100;
         4'd5:    w = 12'd90;
         4'd6:    w = 12'd50;
         4'd7:    w = 12'd40;
         4'd8:    w = 12'd10;
         4'd9:    w = 12'd9;
         4'd10:   w = 12'd5;
         4'd11:   w = 12'd4;
         4'd12:   w = 12'd1;
         default: w = 12'd0;
      endcase
      return w;
   endfunction

   function automatic logic [LetterWidth-1:0] sym_first(input logic [IdxWidth-1:0] idx);
      logic [LetterWidth-1:0] c;
      unique case (idx)
         4'd0:    c = CHAR_M;
         4'd1:    c = CHAR_C;
         4'd2:    c = CHAR_D;
         4'd3:    c = CHAR_C;
         4'd4:    c = CHAR_C;
         4'd5:    c = CHAR_X;
         4'd6:    c = CHAR_L;
         4'd7:    c = CHAR_X;
         4'd8:    c = CHAR_X;
         4'd9:    c = CHAR_I;
         4'd10:   c = CHAR_V;
         4'd11:   c = CHAR_I;
         4'd12:   c = CHAR_I;
         default: c = CHAR_NONE;
      endcase
      return c;
   endfunction

   function automatic logic [LetterWidth-1:0] sym_second(input logic [IdxWidth-1:0] idx);
      logic [LetterWidth-1:0] c;
      unique case (idx)
         4'd1:    c = CHAR_M;
         4'd3:    c = CHAR_D;
         4'd5:    c = CHAR_C;
         4'd7:    c = CHAR_L;
         4'd9:    c = CHAR_X;
         4'd11:   c = CHAR_V;
         default: c = CHAR_NONE;
      endcase
      return c;
   endfunction

   function automatic logic sym_pair(input logic [IdxWidth-1:0] idx);
      return (idx == 4'd1) || (idx == 4'd3) || (idx == 4'd5) ||
             (idx == 4'd7) || (idx == 4'd9) || (idx == 4'd11);
   endfunction

endpackage

FILE: design/i2r_sequencer.sv
// ----------------------------------------------------------------------------
// i2r_sequencer
// Step counter and microprogram ROM; picks the next step from two
// conditional jumps and a default target.
// ----------------------------------------------------------------------------
module i2r_sequencer
   import i2r_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  cond_flags_type flags,
   output ctl_word_type   ctl
);

   step_type step_ff;
   step_type step_in;
   logic     hold;

   function automatic ctl_word_type ucode(input step_type s);
      ctl_word_type w;
      unique case (s)
         STEP_IDLE:   w = '{accept: 1'b1, emit_sel: EMIT_NONE,
                            cond_a: COND_NO_REQ, tgt_a: STEP_IDLE,
                            cond_b: COND_BAD,    tgt_b: STEP_ERROR,
                            tgt_def: STEP_FIRST};
         STEP_FIRST:  w = '{accept: 1'b0, emit_sel: EMIT_FIRST,
                            cond_a: COND_PAIR,   tgt_a: STEP_SECOND,
                            cond_b: COND_DONE,   tgt_b: STEP_IDLE,
                            tgt_def: STEP_FIRST};
         STEP_SECOND: w = '{accept: 1'b0, emit_sel: EMIT_SECOND,
                            cond_a: COND_DONE,   tgt_a: STEP_IDLE,
                            cond_b: COND_NEVER,  tgt_b: STEP_IDLE,
                            tgt_def: STEP_FIRST};
         STEP_ERROR:  w = '{accept: 1'b0, emit_sel: EMIT_ERROR,
                            cond_a: COND_NEVER,  tgt_a: STEP_IDLE,
                            cond_b: COND_NEVER,  tgt_b: STEP_IDLE,
                            tgt_def: STEP_IDLE};
         default:     w = '{accept: 1'b0, emit_sel: EMIT_NONE,
                            cond_a: COND_NEVER,  tgt_a: STEP_IDLE,
                            cond_b: COND_NEVER,  tgt_b: STEP_IDLE,
                            tgt_def: STEP_IDLE};
      endcase
      return w;
   endfunction

   function automatic logic test(input cond_type c, input cond_flags_type f);
      logic r;
      unique case (c)
         COND_NEVER:  r = 1'b0;
         COND_NO_REQ: r = f.no_req;
         COND_BAD:    r = f.bad_value;
         COND_PAIR:   r = f.pair;
         COND_DONE:   r = f.done;
         default:     r = 1'b0;
      endcase
      return r;
   endfunction

   assign ctl  = ucode(step_ff);
   // an emitting step waits while the output register is still full
   assign hold = flags.stall && (ctl.emit_sel != EMIT_NONE);

   always_comb begin
      priority if (hold)               step_in = step_ff;
      else if (test(ctl.cond_a, flags)) step_in = ctl.tgt_a;
      else if (test(ctl.cond_b, flags)) step_in = ctl.tgt_b;
      else                              step_in = ctl.tgt_def;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

FILE: design/integer_to_roman_numeral.sv
// ----------------------------------------------------------------------------
// integer_to_roman_numeral
// Converts a 12-bit binary number into its Roman numeral, one ASCII letter
// per result transaction, last letter flagged; out-of-range values give a
// single error transaction.
//
//   channel  dir  payload                              transaction per
//   req_     in   tdata[11:0] value                    number
//   rsp_     out  tdata[6:0] letter, tlast, tuser err  letter
//
// A number is taken in the idle step, then its letters (up to 15) are
// emitted; an error gives one transaction. The microprogram step
// counter emits at most one letter per cycle from a greedy symbol search.
// Reset returns the sequencer to its idle step and empties the output
// register. A stalled output register holds the sequencer on its step.
// ----------------------------------------------------------------------------
module integer_to_roman_numeral
   import i2r_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [11:0] value, [15:12] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [6:0] letter, [7] zero
   output logic        rsp_tlast,
   output logic        rsp_tuser    // [0] error
);

   ctl_word_type   ctl;
   cond_flags_type flags;

   logic [ValueWidth-1:0]  req_value;
   logic [ValueWidth-1:0]  value_ff, value_in;
   logic [IdxWidth-1:0]    idx_ff, idx_in;
   logic [IdxWidth-1:0]    idx;
   logic [ValueWidth-1:0]  residual;
   logic                   bad_value;
   logic                   stall;
   logic                   fire;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [LetterWidth-1:0] letter_ff, letter_in;
   logic                   last_ff, last_in;
   logic                   error_ff, error_in;

   assign req_value = req_tdata[ValueWidth-1:0];
   assign bad_value = (req_value == '0) || (req_value > MAX_VALUE);

   assign idx      = greedy_idx(value_ff);
   assign residual = value_ff - sym_weight(idx);

   assign stall = rsp_valid_ff && !rsp_tready;
   assign fire  = (ctl.emit_sel != EMIT_NONE) && !stall;

   always_comb begin
      flags.no_req    = !req_tvalid;
      flags.bad_value = bad_value;
      flags.pair      = sym_pair(idx);
      flags.done      = (ctl.emit_sel == EMIT_FIRST) ? (residual == '0) : (value_ff == '0);
      flags.stall     = stall;
   end

   i2r_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctl   (ctl)
   );

   assign req_tready = ctl.accept;

   always_comb begin
      value_in = value_ff;
      idx_in   = idx_ff;
      if (ctl.accept && req_tvalid) begin
         value_in = req_value;
      end else if (fire && (ctl.emit_sel == EMIT_FIRST)) begin
         value_in = residual;
         idx_in   = idx;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      letter_in    = letter_ff;
      last_in      = last_ff;
      error_in     = error_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         unique case (ctl.emit_sel)
            EMIT_FIRST: begin
               letter_in = sym_first(idx);
               last_in   = (residual == '0) && !sym_pair(idx);
               error_in  = 1'b0;
            end
            EMIT_SECOND: begin
               letter_in = sym_second(idx_ff);
               last_in   = (value_ff == '0);
               error_in  = 1'b0;
            end
            EMIT_ERROR: begin
               letter_in = CHAR_NONE;
               last_in   = 1'b1;
               error_in  = 1'b1;
            end
            default: begin
               letter_in = CHAR_NONE;
               last_in   = 1'b0;
               error_in  = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      value_ff  <= value_in;
      idx_ff    <= idx_in;
      letter_ff <= letter_in;
      last_ff   <= last_in;
      error_ff  <= error_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, letter_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = error_ff;

endmodule

FILE: sim/integer_to_roman_numeral_tb.sv
// ----------------------------------------------------------------------------
// integer_to_roman_numeral_tb
// Drives numbers into the converter and checks every letter transaction
// against a local numeral predictor: boundary and out-of-range values, each
// digit form, back-to-back traffic, then a long random run. Both stream
// sides insert random gaps and stalls.
// ----------------------------------------------------------------------------
module integer_to_roman_numeral_tb
   import i2r_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RandomItems = 285;
   localparam int unsigned MaxIdle     = 14;
   localparam int unsigned DrainCycles = 20;
   // worst case ~310 numbers at the longest numeral and stalls, taken several times over
   localparam int unsigned TimeoutNs   = 5_000_000;

   // per decimal place: hundreds, tens, ones
   localparam logic [LetterWidth-1:0] OnesLetter [3] = '{CHAR_C, CHAR_X, CHAR_I};
   localparam logic [LetterWidth-1:0] FiveLetter [3] = '{CHAR_D, CHAR_L, CHAR_V};
   localparam logic [LetterWidth-1:0] TenLetter  [3] = '{CHAR_M, CHAR_C, CHAR_X};

   typedef struct packed {
      logic [LetterWidth-1:0] letter;
      logic                   last;
      logic                   error;
   } roman_letter_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;    // [11:0] value, [15:12] zero
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;    // [6:0] letter, [7] zero
   logic        rsp_tlast;
   logic        rsp_tuser;    // [0] error

   roman_letter_type pending_letters[$];
   int unsigned      mismatch_count = 0;
   bit               no_idle = 1'b0;

   integer_to_roman_numeral u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Queue up the letters of one number's numeral.
   task automatic predict_numeral(input logic [ValueWidth-1:0] value);
      logic [LetterWidth-1:0] run[$];
      int unsigned            v;
      int unsigned            digit [3];
      int unsigned            d;
      roman_letter_type       item;
      v = 32'(value);
      if (v == 0 || v > MAX_VALUE) begin
         item.letter = CHAR_NONE;
         item.last   = 1'b1;
         item.error  = 1'b1;
         pending_letters.push_back(item);
         return;
      end
      repeat (v / 1000) run.push_back(CHAR_M);
      digit[0] = (v % 1000) / 100;
      digit[1] = (v % 100) / 10;
      digit[2] = v % 10;
      for (int p = 0; p < 3; p++) begin
         d = digit[p];
         if (d == 4 || d == 9) run.push_back(OnesLetter[p]);
         if (d >= 4 && d <= 8) run.push_back(FiveLetter[p]);
         if (d == 9) run.push_back(TenLetter[p]);
         if (d % 5 < 4) repeat (d % 5) run.push_back(OnesLetter[p]);
      end
      foreach (run[k]) begin
         item.letter = run[k];
         item.last   = (k == run.size() - 1);
         item.error  = 1'b0;
         pending_letters.push_back(item);
      end
   endtask

   // Valid is only lowered when a gap is taken, so back-to-back numbers
   // never see two assignments to it in one step.
   task automatic send_number(input logic [ValueWidth-1:0] value);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, MaxIdle);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, value};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_numeral(value);
   endtask

   task automatic test_range_limits();
      send_number(12'd1);
      send_number(12'd3999);
      send_number(12'd3888);
      send_number(12'd0);
      send_number(12'd4000);
      send_number(12'd4095);
   endtask

   // subtractive pairs, five-letter forms and repeats in each place
   task automatic test_digit_forms();
      send_number(12'd4);
      send_number(12'd9);
      send_number(12'd5);
      send_number(12'd8);
      send_number(12'd3);
      send_number(12'd40);
      send_number(12'd90);
      send_number(12'd400);
      send_number(12'd900);
      send_number(12'd1994);
      send_number(12'd2444);
      send_number(12'd3000);
      send_number(12'd1111);
   endtask

   task automatic test_back_to_back();
      no_idle = 1'b1;
      send_number(12'd3888);
      send_number(12'd0);
      send_number(12'd1);
      send_number(12'd4095);
      send_number(12'd3999);
      send_number(12'd7);
      no_idle = 1'b0;
   endtask

   task automatic test_random_numbers();
      int unsigned pick;
      logic [ValueWidth-1:0] value;
      for (int unsigned i = 0; i < RandomItems; i++) begin
         // the last ten of every fifty numbers run without any idling
         no_idle = (i % 50) >= 40;
         pick = $urandom_range(0, 99);
         if (pick < 70)      value = ValueWidth'($urandom_range(1, 3999));
         else if (pick < 85) value = ValueWidth'($urandom_range(1, 60));
         else if (pick < 95) value = ValueWidth'($urandom_range(4000, 4095));
         else                value = 12'd0;
         send_number(value);
      end
      no_idle = 1'b0;
   endtask

   // result side: random stall per letter, then check the transaction
   initial begin : letter_checker
      int unsigned      stall;
      roman_letter_type want;
      rsp_tready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, MaxIdle);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (rsp_tvalid !== 1'b1) @(posedge clock);
         if (pending_letters.size() == 0) begin
            $error("unexpected letter transaction: letter %0h last %0b error %0b",
                   rsp_tdata[6:0], rsp_tlast, rsp_tuser);
            mismatch_count++;
         end else begin
            want = pending_letters.pop_front();
            if (rsp_tdata[6:0] !== want.letter) begin
               $error("letter: expected %0h, actual %0h", want.letter, rsp_tdata[6:0]);
               mismatch_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0b, actual %0b", want.last, rsp_tlast);
               mismatch_count++;
            end
            if (rsp_tuser !== want.error) begin
               $error("error: expected %0b, actual %0b", want.error, rsp_tuser);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : timeout_guard
      #(TimeoutNs);
      $display("end of test: mismatches");
      $finish;
   end

   initial begin : run_tests
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_range_limits();
      test_digit_forms();
      test_back_to_back();
      test_random_numbers();
      req_tvalid <= 1'b0;

      while (pending_letters.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (pending_letters.size() != 0) begin
         $error("%0d letters never arrived", pending_letters.size());
         mismatch_count++;
      end

      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
